### sv/rotated_canvas_pixel_store_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rotated canvas pixel store
// Shared property shorthands; each samples on clk and is off during reset.
// ----------------------------------------------------------------------------
// Include guard for this header.
`ifndef ROTATED_CANVAS_PIXEL_STORE_CORE_DEFINES_SVH
`define ROTATED_CANVAS_PIXEL_STORE_CORE_DEFINES_SVH

// Overlapping implication: when ante holds, cons must hold in the same cycle.
`define RCPS_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcps assertion failed");

// Non-overlapping implication: when ante holds, cons must hold in the next cycle.
`define RCPS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcps assertion failed");

`endif

### sv/rcps_pkg.sv
// ----------------------------------------------------------------------------
// rcps_pkg
// Types, constants and helper functions shared by the pixel store modules.
// ----------------------------------------------------------------------------
package rcps_pkg;

    localparam int  PANEL_WIDTH     = 64;
    localparam int  PANEL_HEIGHT    = 32;
    localparam int  MAX_PAD         = 8;
    localparam bit  DOUBLE_BUFFERED = 1'b0;

    // The store is indexed {row, col}, so the width is taken as a power of two.
    localparam int COL_W  = $clog2(PANEL_WIDTH);
    localparam int ROW_W  = $clog2(PANEL_HEIGHT);
    localparam int ADDR_W = COL_W + ROW_W;

    // Signed working width for coordinate arithmetic.
    localparam int CRD_W = 10;

    localparam int PADDR_W = 5;
    localparam int APB_DW  = 32;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_PUSH = 1'b1;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_REFRESH = 2'd2,
        OP_RAW     = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_ROTATION    = 3'd0,
        REG_PADDING     = 3'd1,
        REG_CLIP_LEFT   = 3'd2,
        REG_CLIP_RIGHT  = 3'd3,
        REG_COLOR_ORDER = 3'd4,
        REG_GAIN_RED    = 3'd5,
        REG_GAIN_GREEN  = 3'd6,
        REG_GAIN_BLUE   = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        ORD_RGB = 3'd0,
        ORD_RBG = 3'd1,
        ORD_GRB = 3'd2,
        ORD_BGR = 3'd3,
        ORD_BRG = 3'd4,
        ORD_GBR = 3'd5
    } order_t;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_LOOK  = 2'd2,
        ST_MAP   = 2'd3
    } state_t;

    typedef struct packed {
        logic [1:0] rotation;
        logic [3:0] padding;
        logic [6:0] clip_left;
        logic [6:0] clip_right;
        logic [2:0] color_order;
        logic [7:0] gain_red;
        logic [7:0] gain_green;
        logic [7:0] gain_blue;
    } cfg_t;

    typedef struct packed {
        logic             hit;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } xf_t;

    // Exact x / 255 for any product of two 8-bit values.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] sum;
        begin
            sum = {1'b0, x} + 17'(x[15:8]) + 17'd1;
            div255 = sum[15:8];
        end
    endfunction

endpackage

### sv/rcps_ram.sv
// ----------------------------------------------------------------------------
// rcps_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rcps_ram #(
    parameter int AW = 11,
    parameter int DW = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [1 << AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/rcps_regs.sv
// ----------------------------------------------------------------------------
// rcps_regs
// APB register file holding rotation, padding, clip, channel order and gains.
// ----------------------------------------------------------------------------
module rcps_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rcps_pkg::PADDR_W-1:0] paddr,
    input  logic [rcps_pkg::APB_DW-1:0]  pwdata,
    output logic [rcps_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output rcps_pkg::cfg_t               cfg
);

    rcps_pkg::cfg_t    cfg_reg;
    rcps_pkg::reg_idx_t idx;
    logic              wr_en;
    logic [3:0]        pad_sat;

    assign idx     = rcps_pkg::reg_idx_t'(paddr[rcps_pkg::PADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;
    // Padding beyond the maximum saturates.
    assign pad_sat = (pwdata[3:0] > 4'(rcps_pkg::MAX_PAD)) ? 4'(rcps_pkg::MAX_PAD)
                                                           : pwdata[3:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rotation    <= '0;
            cfg_reg.padding     <= '0;
            cfg_reg.clip_left   <= '0;
            cfg_reg.clip_right  <= 7'd64;
            cfg_reg.color_order <= '0;
            cfg_reg.gain_red    <= 8'hFF;
            cfg_reg.gain_green  <= 8'hFF;
            cfg_reg.gain_blue   <= 8'hFF;
        end
        else if (wr_en)
        begin
            unique case (idx)
                rcps_pkg::REG_ROTATION:    cfg_reg.rotation    <= pwdata[1:0];
                rcps_pkg::REG_PADDING:     cfg_reg.padding     <= pad_sat;
                rcps_pkg::REG_CLIP_LEFT:   cfg_reg.clip_left   <= pwdata[6:0];
                rcps_pkg::REG_CLIP_RIGHT:  cfg_reg.clip_right  <= pwdata[6:0];
                rcps_pkg::REG_COLOR_ORDER: cfg_reg.color_order <= pwdata[2:0];
                rcps_pkg::REG_GAIN_RED:    cfg_reg.gain_red    <= pwdata[7:0];
                rcps_pkg::REG_GAIN_GREEN:  cfg_reg.gain_green  <= pwdata[7:0];
                rcps_pkg::REG_GAIN_BLUE:   cfg_reg.gain_blue   <= pwdata[7:0];
                default:                   cfg_reg.rotation    <= cfg_reg.rotation;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            rcps_pkg::REG_ROTATION:    prdata = 32'(cfg_reg.rotation);
            rcps_pkg::REG_PADDING:     prdata = 32'(cfg_reg.padding);
            rcps_pkg::REG_CLIP_LEFT:   prdata = 32'(cfg_reg.clip_left);
            rcps_pkg::REG_CLIP_RIGHT:  prdata = 32'(cfg_reg.clip_right);
            rcps_pkg::REG_COLOR_ORDER: prdata = 32'(cfg_reg.color_order);
            rcps_pkg::REG_GAIN_RED:    prdata = 32'(cfg_reg.gain_red);
            rcps_pkg::REG_GAIN_GREEN:  prdata = 32'(cfg_reg.gain_green);
            rcps_pkg::REG_GAIN_BLUE:   prdata = 32'(cfg_reg.gain_blue);
            default:                   prdata = '0;
        endcase
    end

endmodule

### sv/rcps_xform.sv
// ----------------------------------------------------------------------------
// rcps_xform
// Bounds and clip checks plus the logical-to-panel rotation of one item.
// ----------------------------------------------------------------------------
module rcps_xform (
    input  rcps_pkg::cfg_t      cfg,
    input  rcps_pkg::op_t       op,
    input  logic signed [7:0]   coord_x,
    input  logic signed [7:0]   coord_y,
    output rcps_pkg::xf_t       xf
);

    localparam int CW = rcps_pkg::CRD_W;
    localparam logic signed [CW-1:0] PW_S = CW'(rcps_pkg::PANEL_WIDTH);
    localparam logic signed [CW-1:0] PH_S = CW'(rcps_pkg::PANEL_HEIGHT);

    logic signed [CW-1:0] xs, ys, pad_s, lw, lh, xp, yp, cx, cy, cl_s, cr_s;
    logic                 in_log, clip_ok, pan_ok;

    always_comb
    begin
        xs    = CW'(coord_x);
        ys    = CW'(coord_y);
        pad_s = CW'(cfg.padding);
        cl_s  = CW'(cfg.clip_left);
        cr_s  = CW'(cfg.clip_right);

        // Quarter and three-quarter turns swap the logical width and height.
        lw = (cfg.rotation[0] ? PH_S : PW_S) - (pad_s <<< 1);
        lh = (cfg.rotation[0] ? PW_S : PH_S) - (pad_s <<< 1);

        in_log  = (xs >= 0) && (ys >= 0) && (xs < lw) && (ys < lh);
        clip_ok = (xs >= cl_s) && (xs < cr_s);
        pan_ok  = (xs >= 0) && (ys >= 0) && (xs < PW_S) && (ys < PH_S);

        xp = xs + pad_s;
        yp = ys + pad_s;

        case (cfg.rotation)
            2'd1:
            begin
                cx = yp;
                cy = PH_S - CW'(1) - xp;
            end
            2'd2:
            begin
                cx = PW_S - CW'(1) - xp;
                cy = PH_S - CW'(1) - yp;
            end
            2'd3:
            begin
                cx = PW_S - CW'(1) - yp;
                cy = xp;
            end
            default:
            begin
                cx = xp;
                cy = yp;
            end
        endcase

        case (op)
            rcps_pkg::OP_WRITE:
            begin
                xf.hit = in_log && clip_ok;
                xf.col = cx[rcps_pkg::COL_W-1:0];
                xf.row = cy[rcps_pkg::ROW_W-1:0];
            end
            rcps_pkg::OP_READ:
            begin
                xf.hit = in_log;
                xf.col = cx[rcps_pkg::COL_W-1:0];
                xf.row = cy[rcps_pkg::ROW_W-1:0];
            end
            default:
            begin
                xf.hit = pan_ok;
                xf.col = xs[rcps_pkg::COL_W-1:0];
                xf.row = ys[rcps_pkg::ROW_W-1:0];
            end
        endcase
    end

endmodule

### sv/rcps_cmap.sv
// ----------------------------------------------------------------------------
// rcps_cmap
// Two-step color map: channel expansion and gain products, then the divide
// by 255, channel permutation and RGB565 packing.
// ----------------------------------------------------------------------------
module rcps_cmap (
    input  logic           clk,
    input  logic           load,
    input  logic [15:0]    color,
    input  rcps_pkg::cfg_t cfg,
    output logic [15:0]    mapped
);

    logic [7:0]  r8, g8, b8;
    logic [15:0] prod_r_reg, prod_g_reg, prod_b_reg;
    logic [7:0]  r, g, b, a0, a1, a2;

    // Replicate the top bits so full scale stays full scale.
    assign r8 = {color[15:11], color[15:13]};
    assign g8 = {color[10:5], color[10:9]};
    assign b8 = {color[4:0], color[4:2]};

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_r_reg <= {8'd0, r8} * {8'd0, cfg.gain_red};
            prod_g_reg <= {8'd0, g8} * {8'd0, cfg.gain_green};
            prod_b_reg <= {8'd0, b8} * {8'd0, cfg.gain_blue};
        end
    end

    always_comb
    begin
        r = rcps_pkg::div255(prod_r_reg);
        g = rcps_pkg::div255(prod_g_reg);
        b = rcps_pkg::div255(prod_b_reg);
        case (rcps_pkg::order_t'(cfg.color_order))
            rcps_pkg::ORD_RBG: begin a0 = r; a1 = b; a2 = g; end
            rcps_pkg::ORD_GRB: begin a0 = g; a1 = r; a2 = b; end
            rcps_pkg::ORD_BGR: begin a0 = b; a1 = g; a2 = r; end
            rcps_pkg::ORD_BRG: begin a0 = b; a1 = r; a2 = g; end
            rcps_pkg::ORD_GBR: begin a0 = g; a1 = b; a2 = r; end
            default:           begin a0 = r; a1 = g; a2 = b; end
        endcase
        mapped = {a0[7:3], a1[7:2], a2[7:3]};
    end

endmodule

### sv/rotated_canvas_pixel_store_core.sv
// ----------------------------------------------------------------------------
// rotated_canvas_pixel_store_core
// Shadow framebuffer for an RGB565 LED panel with rotation, padding, clipping
// and change-only pixel pushes through a gain and channel-order color map.
// ----------------------------------------------------------------------------
// After reset the block sweeps both pixel memories to zero, one entry per
// cycle over all 2048 entries, and holds busy high meanwhile; register
// writes are taken throughout. An item is taken when start is high and busy
// is low. A logical write or read holds the block for the accept and then
// the memory read in ST_LOOK. A refresh or raw write on the panel holds it
// also through ST_MAP for the gain division and compare; one off the panel
// is dropped after ST_LOOK. A new item is taken only once the last has
// finished. The read-modify-write through the registered memory read port and
// the registered gain multiply set these steps. A result appears on the result
// ports for exactly one cycle, flagged by done, in the cycle after the item's
// last busy cycle; the receiver cannot hold results off, so it must take
// every strobe. Reads return the stored color (zero off the logical area)
// with column and row zero; pushes return the mapped color and panel position.
// Registers may be written only while the block is idle.
module rotated_canvas_pixel_store_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rcps_pkg::PADDR_W-1:0] paddr,
    input  logic [rcps_pkg::APB_DW-1:0]  pwdata,
    output logic [rcps_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   operation,
    input  logic signed [7:0]            coord_x,
    input  logic signed [7:0]            coord_y,
    input  logic [15:0]                  pixel_color,
    output logic                         done,
    output logic                         result_kind,
    output logic [15:0]                  out_color,
    output logic [rcps_pkg::COL_W-1:0]   panel_col,
    output logic [rcps_pkg::ROW_W-1:0]   panel_row
);

    localparam int AW = rcps_pkg::ADDR_W;

    rcps_pkg::cfg_t   cfg;
    rcps_pkg::xf_t    xf;
    rcps_pkg::state_t state_reg, state_next;

    logic [AW-1:0]              clr_cnt_reg, clr_cnt_next;
    rcps_pkg::op_t              op_reg;
    logic                       hit_reg;
    logic [rcps_pkg::COL_W-1:0] col_reg;
    logic [rcps_pkg::ROW_W-1:0] row_reg;
    logic [15:0]                color_reg;

    logic                       done_reg, done_next;
    logic                       kind_reg, kind_next;
    logic [15:0]                ocol_reg, ocol_next;
    logic [rcps_pkg::COL_W-1:0] pcol_reg, pcol_next;
    logic [rcps_pkg::ROW_W-1:0] prow_reg, prow_next;

    logic          accept, clearing;
    logic          sh_we, sw_we, cm_load;
    logic [AW-1:0] item_addr, rd_addr, wr_addr;
    logic [15:0]   shadow_q, shown_q, mapped, cm_src;

    assign accept    = start && (state_reg == rcps_pkg::ST_IDLE);
    assign busy      = (state_reg != rcps_pkg::ST_IDLE);
    assign clearing  = (state_reg == rcps_pkg::ST_CLEAR);
    assign rd_addr   = {xf.row, xf.col};
    assign item_addr = {row_reg, col_reg};
    assign wr_addr   = clearing ? clr_cnt_reg : item_addr;
    // A refresh maps what the shadow store holds; the other ops map their own color.
    assign cm_src    = (op_reg == rcps_pkg::OP_REFRESH) ? shadow_q : color_reg;

    assign done        = done_reg;
    assign result_kind = kind_reg;
    assign out_color   = ocol_reg;
    assign panel_col   = pcol_reg;
    assign panel_row   = prow_reg;

    rcps_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rcps_xform u_xform (
        .cfg     (cfg),
        .op      (rcps_pkg::op_t'(operation)),
        .coord_x (coord_x),
        .coord_y (coord_y),
        .xf      (xf)
    );

    // Shadow store: the logical image, written by logical writes.
    rcps_ram #(.AW(AW), .DW(16)) u_shadow (
        .clk   (clk),
        .we    (sh_we),
        .waddr (wr_addr),
        .wdata (clearing ? 16'd0 : color_reg),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (shadow_q)
    );

    // Shown store: the mapped color the panel currently displays.
    rcps_ram #(.AW(AW), .DW(16)) u_shown (
        .clk   (clk),
        .we    (sw_we),
        .waddr (wr_addr),
        .wdata (clearing ? 16'd0 : mapped),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (shown_q)
    );

    rcps_cmap u_cmap (
        .clk    (clk),
        .load   (cm_load),
        .color  (cm_src),
        .cfg    (cfg),
        .mapped (mapped)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rcps_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= done_next;
        end
    end

    // Item and result payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= rcps_pkg::op_t'(operation);
            hit_reg   <= xf.hit;
            col_reg   <= xf.col;
            row_reg   <= xf.row;
            color_reg <= pixel_color;
        end
        kind_reg <= kind_next;
        ocol_reg <= ocol_next;
        pcol_reg <= pcol_next;
        prow_reg <= prow_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        done_next    = 1'b0;
        kind_next    = kind_reg;
        ocol_next    = ocol_reg;
        pcol_next    = pcol_reg;
        prow_next    = prow_reg;
        sh_we        = 1'b0;
        sw_we        = 1'b0;
        cm_load      = 1'b0;

        unique case (state_reg)
            rcps_pkg::ST_CLEAR:
            begin
                sh_we        = 1'b1;
                sw_we        = 1'b1;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == '1)
                begin
                    state_next = rcps_pkg::ST_IDLE;
                end
            end
            rcps_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = rcps_pkg::ST_LOOK;
                end
            end
            rcps_pkg::ST_LOOK:
            begin
                // Memory data for the item is valid in this cycle.
                cm_load    = 1'b1;
                state_next = rcps_pkg::ST_IDLE;
                case (op_reg)
                    rcps_pkg::OP_WRITE:
                    begin
                        sh_we = hit_reg;
                        if (hit_reg && rcps_pkg::DOUBLE_BUFFERED)
                        begin
                            state_next = rcps_pkg::ST_MAP;
                        end
                    end
                    rcps_pkg::OP_READ:
                    begin
                        done_next = 1'b1;
                        kind_next = rcps_pkg::KIND_READ;
                        ocol_next = hit_reg ? shadow_q : 16'd0;
                        pcol_next = '0;
                        prow_next = '0;
                    end
                    rcps_pkg::OP_REFRESH:
                    begin
                        if (hit_reg && !rcps_pkg::DOUBLE_BUFFERED)
                        begin
                            state_next = rcps_pkg::ST_MAP;
                        end
                    end
                    default:
                    begin
                        if (hit_reg)
                        begin
                            state_next = rcps_pkg::ST_MAP;
                        end
                    end
                endcase
            end
            rcps_pkg::ST_MAP:
            begin
                state_next = rcps_pkg::ST_IDLE;
                // Single buffered, only a changed pixel is pushed and recorded.
                if (rcps_pkg::DOUBLE_BUFFERED || (mapped != shown_q))
                begin
                    done_next = 1'b1;
                    kind_next = rcps_pkg::KIND_PUSH;
                    ocol_next = mapped;
                    pcol_next = col_reg;
                    prow_next = row_reg;
                    sw_we     = !rcps_pkg::DOUBLE_BUFFERED;
                end
            end
            default:
            begin
                state_next = rcps_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### sv/rcps_checker.sv
// ----------------------------------------------------------------------------
// rcps_checker
// Port-level checks of the pixel store's start/busy and result strobe timing.
// ----------------------------------------------------------------------------
`include "rotated_canvas_pixel_store_core_defines.svh"

module rcps_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       done,
    input logic                       result_kind,
    input logic [rcps_pkg::COL_W-1:0] panel_col,
    input logic [rcps_pkg::ROW_W-1:0] panel_row
);

    // An accepted item always occupies the block for the following cycle.
    `RCPS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // No result can come out in the cycle right after an accept.
    `RCPS_ASSERT_NEXT(a_accept_no_done, start && !busy, !done)
    // Results only show once the item has finished.
    `RCPS_ASSERT_SAME(a_done_idle, done, !busy)
    // Every item holds busy after its accept, so strobes never touch.
    `RCPS_ASSERT_NEXT(a_done_single, done, !done)
    // Read results carry a zero panel position.
    `RCPS_ASSERT_SAME(a_read_pos, done && (result_kind == rcps_pkg::KIND_READ),
                      (panel_col == '0) && (panel_row == '0))

endmodule

bind rotated_canvas_pixel_store_core rcps_checker u_rcps_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .result_kind (result_kind),
    .panel_col   (panel_col),
    .panel_row   (panel_row)
);
